>>> src/indexed_list_insert_delete_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list block
// Concurrent assertion wrappers that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_MACROS_SVH

`ifndef SYNTH
`define ILID_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ILID_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ILID_ASSERT(label, clk, rst_n, prop, msg)
`define ILID_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> src/ilid_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list package
// Sizes, action and status codes, and the control bundle sent to each cell.
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int DEPTH = 64;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PW    = $clog2(DEPTH);
  localparam int VW    = 32;

  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_POP    = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_READ   = 3'd4,
    ACT_FIND   = 3'd5
  } action_e;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [CW-1:0]     op_idx;
    logic [VW-1:0]     op_val;
    logic              clear;
    logic              sweep;
    logic              find;
    logic [VW-1:0]     key;
    logic [CW-1:0]     ridx;
    logic [CW-1:0]     lim;
  } ctrl_t;

  typedef struct packed {
    logic          hit;
    logic [VW-1:0] data;
    logic [PW-1:0] pos;
  } res_t;

endpackage

>>> src/ilid_cell.sv
// ----------------------------------------------------------------------------
// Indexed list cell
// Holds one entry, shifts with its neighbors, and forwards the search token.
// ----------------------------------------------------------------------------
module ilid_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ilid_pkg::CW-1:0] my_idx_i,
  input  ilid_pkg::ctrl_t   ctrl_i,
  input  logic [ilid_pkg::VW-1:0] lower_i,
  input  logic [ilid_pkg::VW-1:0] upper_i,
  output logic [ilid_pkg::VW-1:0] value_o,
  input  ilid_pkg::res_t    res_i,
  output ilid_pkg::res_t    res_o
);
  import ilid_pkg::*;

  logic [VW-1:0] value_q, value_d;
  res_t          res_q, res_d;
  logic          hit;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.op)
      CELL_INSERT: begin
        if (my_idx_i > ctrl_i.op_idx) begin
          value_d = lower_i;
        end else if (my_idx_i == ctrl_i.op_idx) begin
          value_d = ctrl_i.op_val;
        end
      end
      CELL_DELETE: begin
        if (my_idx_i >= ctrl_i.op_idx) begin
          value_d = upper_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign hit = (my_idx_i < ctrl_i.lim) &&
               (ctrl_i.find ? (value_q == ctrl_i.key) : (my_idx_i == ctrl_i.ridx));

  always_comb begin
    res_d = res_q;
    if (ctrl_i.clear) begin
      res_d = '0;
    end else if (ctrl_i.sweep) begin
      if (hit) begin
        res_d.hit  = 1'b1;
        res_d.data = value_q;
        res_d.pos  = my_idx_i[PW-1:0];
      end else begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign value_o = value_q;
  assign res_o   = res_q;

endmodule

>>> src/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Indexed list with insert and delete
// Ordered list of 64 unsigned words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Append, insert, delete, unused actions and every error are answered in the
// cycle after the transaction is taken; the cells move the affected entries
// in that same cycle. For pop, read and find a result token ripples from the
// top cell down to cell 0, one cell per cycle, so the lowest matching entry
// wins. A new transaction is taken once the previous one is finished and the
// result register is free or being drained.
// Input tdata bits: action [2:0], index [9:3], value [41:10], zeros above.
// Output tdata bits: status [2:0], data [34:3], position [40:35], count [47:41].
// ----------------------------------------------------------------------------
module indexed_list_insert_delete (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // action, index, value, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // status, data, position, count
);
  import ilid_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [PW-1:0] swp_q, swp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          find_q, find_d;
  logic [VW-1:0] key_q, key_d;
  logic [CW-1:0] ridx_q, ridx_d;
  logic [CW-1:0] lim_q, lim_d;

  logic          m_valid_q, m_valid_d;
  logic [2:0]    o_status_q, o_status_d;
  logic [VW-1:0] o_data_q, o_data_d;
  logic [PW-1:0] o_pos_q, o_pos_d;
  logic [CW-1:0] o_cnt_q, o_cnt_d;

  logic          acc;
  logic [2:0]    in_act;
  logic [CW-1:0] in_idx;
  logic [VW-1:0] in_val;
  logic          direct;
  logic          start;
  logic [2:0]    dir_status;
  logic          full;
  logic          empty;
  ctrl_t         ctrl;

  logic [VW-1:0] val_w [DEPTH];
  res_t          res_w [DEPTH+1];

  assign in_act = s_axis_tdata[2:0];
  assign in_idx = s_axis_tdata[9:3];
  assign in_val = s_axis_tdata[41:10];
  assign full   = (cnt_q == CW'(DEPTH));
  assign empty  = (cnt_q == '0);

  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.op_idx = in_idx;
    ctrl.op_val = in_val;
    direct      = 1'b0;
    start       = 1'b0;
    dir_status  = ST_OK;
    cnt_d       = cnt_q;
    find_d      = find_q;
    key_d       = key_q;
    ridx_d      = ridx_q;
    lim_d       = lim_q;
    if (acc) begin
      unique case (in_act)
        ACT_APPEND: begin
          direct = 1'b1;
          if (full) begin
            dir_status = ST_FULL;
          end else begin
            ctrl.op     = CELL_INSERT;
            ctrl.op_idx = cnt_q;
            cnt_d       = cnt_q + CW'(1);
          end
        end
        ACT_POP: begin
          if (empty) begin
            direct     = 1'b1;
            dir_status = ST_EMPTY;
          end else begin
            start  = 1'b1;
            cnt_d  = cnt_q - CW'(1);
            find_d = 1'b0;
            ridx_d = cnt_q - CW'(1);
            lim_d  = cnt_q;
          end
        end
        ACT_INSERT: begin
          direct = 1'b1;
          if (in_idx > cnt_q) begin
            dir_status = ST_RANGE;
          end else if (full) begin
            dir_status = ST_FULL;
          end else begin
            ctrl.op = CELL_INSERT;
            cnt_d   = cnt_q + CW'(1);
          end
        end
        ACT_DELETE: begin
          direct = 1'b1;
          if (empty) begin
            dir_status = ST_EMPTY;
          end else if (in_idx >= cnt_q) begin
            dir_status = ST_RANGE;
          end else begin
            ctrl.op = CELL_DELETE;
            cnt_d   = cnt_q - CW'(1);
          end
        end
        ACT_READ: begin
          if (empty) begin
            direct     = 1'b1;
            dir_status = ST_EMPTY;
          end else if (in_idx >= cnt_q) begin
            direct     = 1'b1;
            dir_status = ST_RANGE;
          end else begin
            start  = 1'b1;
            find_d = 1'b0;
            ridx_d = in_idx;
            lim_d  = cnt_q;
          end
        end
        ACT_FIND: begin
          start  = 1'b1;
          find_d = 1'b1;
          key_d  = in_val;
          lim_d  = cnt_q;
        end
        default: begin
          direct = 1'b1;
        end
      endcase
    end
    ctrl.clear = start;
    ctrl.sweep = (state_q == S_SWEEP);
    ctrl.find  = find_q;
    ctrl.key   = key_q;
    ctrl.ridx  = ridx_q;
    ctrl.lim   = lim_q;
  end

  always_comb begin
    state_d = state_q;
    swp_d   = swp_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_SWEEP;
          swp_d   = '0;
        end
      end
      S_SWEEP: begin
        swp_d = swp_q + PW'(1);
        if (swp_q == PW'(DEPTH - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d  = m_valid_q && !m_axis_tready;
    o_status_d = o_status_q;
    o_data_d   = o_data_q;
    o_pos_d    = o_pos_q;
    o_cnt_d    = o_cnt_q;
    if (direct) begin
      m_valid_d  = 1'b1;
      o_status_d = dir_status;
      o_data_d   = '0;
      o_pos_d    = '0;
      o_cnt_d    = cnt_d;
    end else if (state_q == S_FIN) begin
      m_valid_d = 1'b1;
      o_cnt_d   = cnt_q;
      if (find_q) begin
        o_status_d = res_w[0].hit ? ST_OK : ST_NOTFOUND;
        o_data_d   = '0;
        o_pos_d    = res_w[0].hit ? res_w[0].pos : '0;
      end else begin
        o_status_d = ST_OK;
        o_data_d   = res_w[0].data;
        o_pos_d    = '0;
      end
    end
  end

  assign res_w[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VW-1:0] lower;
    logic [VW-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = val_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = val_w[i];
    end else begin : g_upper
      assign upper = val_w[i+1];
    end
    ilid_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .my_idx_i (CW'(i)),
      .ctrl_i   (ctrl),
      .lower_i  (lower),
      .upper_i  (upper),
      .value_o  (val_w[i]),
      .res_i    (res_w[i+1]),
      .res_o    (res_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      swp_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      find_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      swp_q     <= swp_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      find_q    <= find_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    ridx_q     <= ridx_d;
    lim_q      <= lim_d;
    o_status_q <= o_status_d;
    o_data_q   <= o_data_d;
    o_pos_q    <= o_pos_d;
    o_cnt_q    <= o_cnt_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {o_cnt_q, o_pos_q, o_data_q, o_status_q};

`include "indexed_list_insert_delete_macros.svh"

  `ILID_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH), "count above capacity")
  `ILID_ASSERT(a_busy_no_ready, clk_i, rst_ni, (state_q != S_IDLE) |-> !s_axis_tready, "ready while busy")
  `ILID_ASSERT(a_find_sweeps, clk_i, rst_ni, (acc && in_act == ACT_FIND) |=> (state_q == S_SWEEP), "find did not start a sweep")
  `ILID_ASSERT(a_result_source, clk_i, rst_ni, $rose(m_valid_q) |-> $past(state_q == S_FIN || direct), "result without a source")

endmodule
